// ----- rtl/core/fitness_record_stream_parser_assert.svh -----
// Assertion macros shared by the checker of the record stream parser.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef FITNESS_RECORD_STREAM_PARSER_ASSERT_SVH
`define FITNESS_RECORD_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication.
`define FRSP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define FRSP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/core/frsp_pkg.sv -----
// Shared types and constants of the record stream parser.
// No dependencies.
package frsp_pkg;

	localparam int LOCAL_TYPES = 16;
	localparam int MAX_FIELDS  = 256;
	localparam int LT_W        = 4;
	localparam int FP_W        = 8;
	localparam int DEF_AW      = LT_W + FP_W;
	localparam int DEF_DEPTH   = LOCAL_TYPES * MAX_FIELDS;
	localparam int DIVISOR     = 1000;

	localparam logic [7:0]  HDR_LEN_RESET     = 8'd14;
	localparam logic [15:0] MSG_SESSION       = 16'd18;
	localparam logic [15:0] MSG_RECORD        = 16'd20;
	localparam logic [7:0]  FLD_TIMESTAMP     = 8'd253;
	localparam logic [7:0]  FLD_MSG_INDEX     = 8'd254;
	localparam logic [7:0]  FLD_TOTAL_ELAPSED = 8'd7;
	localparam logic [31:0] INDEX_MASK        = 32'h0000_0fff;
	localparam int          BIT_COMPRESSED    = 7;
	localparam int          BIT_DEFINITION    = 6;
	localparam int          BIT_SPECIFIC      = 5;

	typedef enum logic [2:0] {
		PH_HEADER, PH_RECORD, PH_DEFFIX, PH_FIELDDEF, PH_DATA
	} phase_t;

	typedef enum logic [2:0] {
		CT_IDLE, CT_DIV, CT_EMIT, CT_SEEK_RD, CT_SEEK_CHK
	} ctl_t;

	typedef enum logic [1:0] {
		ST_OK, ST_COMPRESSED, ST_SPECIFIC, ST_TOO_MANY
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] msg;
		logic [7:0]  fld;
		logic [31:0] value;
		logic [31:0] elapsed;
		logic        gap;
		logic [7:0]  gap_sec;
	} result_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
	} div_req_t;

endpackage

// ----- rtl/core/frsp_div1000.sv -----
// Divider by the constant divisor: reciprocal multiplication, quotient from the high bits.
// Depends on frsp_pkg.
module frsp_div1000 (
	input  logic               clk,
	input  logic               arst_n,
	input  frsp_pkg::div_req_t req,
	output logic               busy,
	output logic [31:0]        quotient
);

	// ceil(2^38 / divisor); exact for every 32-bit dividend
	localparam logic [31:0] RECIP = 32'(((64'd1 << 38) + 64'(frsp_pkg::DIVISOR) - 64'd1)
		/ 64'(frsp_pkg::DIVISOR));

	logic        busy_q;
	logic [63:0] prod_q;
	logic [31:0] quo_q;

	// busy covers the cycle in which the product is scaled into the quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= req.start;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start)
			prod_q <= 64'(req.dividend) * 64'(RECIP);
		if (busy_q)
			quo_q <= {6'd0, prod_q[63:38]};
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/core/fitness_record_stream_parser.sv -----
// Header, definition and mid-field bytes are accepted while idle. A data record header and the
// last byte of a field add the next-field seek: a read state and a check state per definition
// memory read (one per skipped zero-size field, one for the hit), or only the read state when no
// field is left. A result passes the emit state to load the output register (held there while
// out_stall holds it); the session elapsed time first takes the reciprocal divide state.
// Throughput: 1 byte per cycle inside a field; seeks, divides and result loads stall the input.
// Reset: async active low; header length 14, phase header skip, counts clear, no clear pass.
module fitness_record_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        file_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] message_number,
	output logic [7:0]  field_number,
	output logic [31:0] field_value,
	output logic [31:0] elapsed_seconds,
	output logic        gap_found,
	output logic [7:0]  gap_seconds
);

	// Control and parse state
	frsp_pkg::ctl_t   ctl_q, nx_ctl;
	frsp_pkg::phase_t phase_q, nx_phase;
	logic [7:0]  hdr_len_q;
	logic [7:0]  bp_q, nx_bp;
	logic [3:0]  lt_q, nx_lt;
	logic [7:0]  fp_q, nx_fp;
	logic [31:0] vg_q, nx_vg;
	logic [31:0] ref_q, nx_ref;
	logic        refv_q, nx_refv;
	logic [31:0] prev_q, nx_prev;
	logic        stop_q, nx_stop;
	logic        pend_seek_q, nx_pend_seek;

	// Per local type tables
	logic [15:0] gnum_q [frsp_pkg::LOCAL_TYPES];
	logic [7:0]  cnt_q  [frsp_pkg::LOCAL_TYPES];

	// Field definition store: {field number, size} per local type and slot
	logic [15:0] def_mem [frsp_pkg::DEF_DEPTH];
	logic [15:0] def_rd_q;
	logic [15:0] cur_def_q;
	logic [7:0]  def_hi_q;

	// Result staging and output register
	frsp_pkg::result_t res, pend_q, out_q;
	logic        out_valid_q;

	// Strobes
	logic        acc, res_take, gnum_lo_we, gnum_hi_we, cnt_we, def_hi_we, def_we;
	logic        mem_rd, load_cur, div_take, out_load, do_decode;
	logic [31:0] v, diff, base_ref, base_prev;
	logic [15:0] gnum;
	logic [7:0]  fnum, fsize;
	frsp_pkg::div_req_t div_req;
	logic        div_busy;
	logic [31:0] div_quo;

	assign acc      = in_valid && (ctl_q == frsp_pkg::CT_IDLE);
	assign in_stall = (ctl_q != frsp_pkg::CT_IDLE);
	assign gnum     = gnum_q[lt_q];
	assign fnum     = cur_def_q[15:8];
	assign fsize    = cur_def_q[7:0];

	frsp_div1000 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_comb begin
		nx_ctl       = ctl_q;
		nx_phase     = phase_q;
		nx_bp        = bp_q;
		nx_lt        = lt_q;
		nx_fp        = fp_q;
		nx_vg        = vg_q;
		nx_ref       = ref_q;
		nx_refv      = refv_q;
		nx_prev      = prev_q;
		nx_stop      = stop_q;
		nx_pend_seek = pend_seek_q;
		res          = '0;
		res_take     = 1'b0;
		gnum_lo_we   = 1'b0;
		gnum_hi_we   = 1'b0;
		cnt_we       = 1'b0;
		def_hi_we    = 1'b0;
		def_we       = 1'b0;
		mem_rd       = 1'b0;
		load_cur     = 1'b0;
		div_take     = 1'b0;
		out_load     = 1'b0;
		do_decode    = 1'b0;
		div_req      = '0;
		v            = vg_q;
		diff         = '0;
		base_ref     = ref_q;
		base_prev    = prev_q;
		case (ctl_q)
			frsp_pkg::CT_IDLE: begin
				if (in_valid) begin
					// a file start restarts the parser before this beat is parsed
					if (file_start) begin
						nx_phase = frsp_pkg::PH_HEADER;
						nx_bp    = '0;
						nx_lt    = '0;
						nx_fp    = '0;
						nx_vg    = '0;
						nx_ref   = '0;
						nx_refv  = 1'b0;
						nx_prev  = '0;
						nx_stop  = 1'b0;
					end
					if (!nx_stop) begin
						case (nx_phase)
							frsp_pkg::PH_HEADER: begin
								nx_bp = nx_bp + 8'd1;
								if (nx_bp >= hdr_len_q) begin
									nx_phase = frsp_pkg::PH_RECORD;
									nx_bp    = '0;
								end
							end
							frsp_pkg::PH_RECORD: begin
								if (data_byte[frsp_pkg::BIT_COMPRESSED]) begin
									res.status   = frsp_pkg::ST_COMPRESSED;
									res_take     = 1'b1;
									nx_stop      = 1'b1;
									nx_pend_seek = 1'b0;
									nx_ctl       = frsp_pkg::CT_EMIT;
								end else if (data_byte[frsp_pkg::BIT_SPECIFIC]) begin
									res.status   = frsp_pkg::ST_SPECIFIC;
									res_take     = 1'b1;
									nx_stop      = 1'b1;
									nx_pend_seek = 1'b0;
									nx_ctl       = frsp_pkg::CT_EMIT;
								end else begin
									nx_lt = data_byte[3:0];
									nx_bp = '0;
									nx_fp = '0;
									nx_vg = '0;
									if (data_byte[frsp_pkg::BIT_DEFINITION])
										nx_phase = frsp_pkg::PH_DEFFIX;
									else
										nx_ctl = frsp_pkg::CT_SEEK_RD;
								end
							end
							frsp_pkg::PH_DEFFIX: begin
								if (bp_q == 8'd2) begin
									gnum_lo_we = 1'b1;
									nx_bp      = bp_q + 8'd1;
								end else if (bp_q == 8'd3) begin
									gnum_hi_we = 1'b1;
									nx_bp      = bp_q + 8'd1;
								end else if (bp_q == 8'd4) begin
									if ({1'b0, data_byte} > 9'(frsp_pkg::MAX_FIELDS)) begin
										res.status   = frsp_pkg::ST_TOO_MANY;
										res_take     = 1'b1;
										nx_stop      = 1'b1;
										nx_pend_seek = 1'b0;
										nx_ctl       = frsp_pkg::CT_EMIT;
									end else begin
										cnt_we   = 1'b1;
										nx_bp    = '0;
										nx_fp    = '0;
										nx_phase = (data_byte == 8'd0) ? frsp_pkg::PH_RECORD
											: frsp_pkg::PH_FIELDDEF;
									end
								end else begin
									nx_bp = bp_q + 8'd1;
								end
							end
							frsp_pkg::PH_FIELDDEF: begin
								if (bp_q == 8'd0)
									def_hi_we = 1'b1;
								else if (bp_q == 8'd1)
									def_we = 1'b1;
								if (bp_q >= 8'd2) begin
									nx_bp = '0;
									nx_fp = fp_q + 8'd1;
									if (({1'b0, fp_q} + 9'd1) >= {1'b0, cnt_q[lt_q]})
										nx_phase = frsp_pkg::PH_RECORD;
								end else begin
									nx_bp = bp_q + 8'd1;
								end
							end
							frsp_pkg::PH_DATA: begin
								// gather little-endian, keep only the first four bytes
								if (bp_q < 8'd4)
									v[{bp_q[1:0], 3'b000} +: 8] = vg_q[{bp_q[1:0], 3'b000} +: 8]
										| data_byte;
								nx_vg = v;
								nx_bp = bp_q + 8'd1;
								if (({1'b0, bp_q} + 9'd1) >= {1'b0, fsize}) begin
									do_decode    = 1'b1;
									nx_fp        = fp_q + 8'd1;
									nx_pend_seek = 1'b1;
									nx_ctl       = frsp_pkg::CT_SEEK_RD;
								end
							end
							default: nx_phase = frsp_pkg::PH_RECORD;
						endcase
					end
					// decode a finished field of a recognized message
					if (do_decode) begin
						res.msg = gnum;
						res.fld = fnum;
						res.value = v;
						if (gnum == frsp_pkg::MSG_RECORD) begin
							if (fnum == 8'd3 || fnum == 8'd5 || fnum == 8'd6)
								res_take = 1'b1;
							else if (fnum == frsp_pkg::FLD_TIMESTAMP) begin
								res_take  = 1'b1;
								base_ref  = refv_q ? ref_q : v;
								base_prev = refv_q ? prev_q : v;
								diff      = v - base_prev;
								nx_ref    = base_ref;
								nx_refv   = 1'b1;
								nx_prev   = v;
								res.elapsed = v - base_ref;
								res.gap     = (diff > 32'd1);
								res.gap_sec = diff[7:0];
							end
						end else if (gnum == frsp_pkg::MSG_SESSION) begin
							if (fnum == frsp_pkg::FLD_MSG_INDEX) begin
								res_take  = 1'b1;
								res.value = v & frsp_pkg::INDEX_MASK;
							end else if (fnum == frsp_pkg::FLD_TOTAL_ELAPSED) begin
								res_take         = 1'b1;
								div_req.start    = 1'b1;
								div_req.dividend = v;
							end else if (fnum == 8'd9 || (fnum >= 8'd14 && fnum <= 8'd17))
								res_take = 1'b1;
						end
						if (res_take)
							nx_ctl = div_req.start ? frsp_pkg::CT_DIV : frsp_pkg::CT_EMIT;
					end
				end
			end
			frsp_pkg::CT_DIV: begin
				if (!div_busy) begin
					div_take = 1'b1;
					nx_ctl   = frsp_pkg::CT_EMIT;
				end
			end
			frsp_pkg::CT_EMIT: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					nx_ctl   = pend_seek_q ? frsp_pkg::CT_SEEK_RD : frsp_pkg::CT_IDLE;
				end
			end
			frsp_pkg::CT_SEEK_RD: begin
				if (fp_q >= cnt_q[lt_q]) begin
					nx_phase = frsp_pkg::PH_RECORD;
					nx_ctl   = frsp_pkg::CT_IDLE;
				end else begin
					mem_rd = 1'b1;
					nx_ctl = frsp_pkg::CT_SEEK_CHK;
				end
			end
			frsp_pkg::CT_SEEK_CHK: begin
				// skip zero-size fields, one memory read each
				if (def_rd_q[7:0] == 8'd0) begin
					nx_fp  = fp_q + 8'd1;
					nx_ctl = frsp_pkg::CT_SEEK_RD;
				end else begin
					load_cur = 1'b1;
					nx_bp    = '0;
					nx_vg    = '0;
					nx_phase = frsp_pkg::PH_DATA;
					nx_ctl   = frsp_pkg::CT_IDLE;
				end
			end
			default: nx_ctl = frsp_pkg::CT_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q       <= frsp_pkg::CT_IDLE;
			phase_q     <= frsp_pkg::PH_HEADER;
			hdr_len_q   <= frsp_pkg::HDR_LEN_RESET;
			bp_q        <= '0;
			lt_q        <= '0;
			fp_q        <= '0;
			vg_q        <= '0;
			ref_q       <= '0;
			refv_q      <= 1'b0;
			prev_q      <= '0;
			stop_q      <= 1'b0;
			pend_seek_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < frsp_pkg::LOCAL_TYPES; i++)
				cnt_q[i] <= '0;
		end else begin
			ctl_q       <= nx_ctl;
			phase_q     <= nx_phase;
			bp_q        <= nx_bp;
			lt_q        <= nx_lt;
			fp_q        <= nx_fp;
			vg_q        <= nx_vg;
			ref_q       <= nx_ref;
			refv_q      <= nx_refv;
			prev_q      <= nx_prev;
			stop_q      <= nx_stop;
			pend_seek_q <= nx_pend_seek;
			if (cfg_wr_en)
				hdr_len_q <= cfg_wr_data;
			// drop all field counts on file start
			if (acc && file_start) begin
				for (int i = 0; i < frsp_pkg::LOCAL_TYPES; i++)
					cnt_q[i] <= '0;
			end else if (cnt_we) begin
				cnt_q[lt_q] <= data_byte;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (gnum_lo_we)
			gnum_q[lt_q][7:0] <= data_byte;
		if (gnum_hi_we)
			gnum_q[lt_q][15:8] <= data_byte;
		if (def_hi_we)
			def_hi_q <= data_byte;
		if (def_we)
			def_mem[{lt_q, fp_q}] <= {def_hi_q, data_byte};
		if (mem_rd)
			def_rd_q <= def_mem[{lt_q, fp_q}];
		if (load_cur)
			cur_def_q <= def_rd_q;
		if (res_take)
			pend_q <= res;
		else if (div_take)
			pend_q.value <= div_quo;
		if (out_load)
			out_q <= pend_q;
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign message_number  = out_q.msg;
	assign field_number    = out_q.fld;
	assign field_value     = out_q.value;
	assign elapsed_seconds = out_q.elapsed;
	assign gap_found       = out_q.gap;
	assign gap_seconds     = out_q.gap_sec;

endmodule

// ----- rtl/core/frsp_checker.sv -----
// Port-level checker for the record stream parser, bound to the top level.
// Depends on frsp_pkg and fitness_record_stream_parser_assert.svh.
`include "fitness_record_stream_parser_assert.svh"

module frsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wr_en,
	input logic [7:0]  cfg_wr_data,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  data_byte,
	input logic        file_start,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [15:0] message_number,
	input logic [7:0]  field_number,
	input logic [31:0] field_value,
	input logic [31:0] elapsed_seconds,
	input logic        gap_found,
	input logic [7:0]  gap_seconds
);

	`FRSP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
	`FRSP_ASSERT_IMP(a_err_zero, out_valid && (status != frsp_pkg::ST_OK), message_number == 16'd0 && field_number == 8'd0 && field_value == 32'd0)
	`FRSP_ASSERT_IMP(a_msg_known, out_valid && (status == frsp_pkg::ST_OK), message_number == frsp_pkg::MSG_SESSION || message_number == frsp_pkg::MSG_RECORD)
	`FRSP_ASSERT_IMP(a_time_only, out_valid && (field_number != frsp_pkg::FLD_TIMESTAMP), elapsed_seconds == 32'd0 && !gap_found && gap_seconds == 8'd0)

endmodule

bind fitness_record_stream_parser frsp_checker u_frsp_checker (.*);
